// ----- src/bzpath_pkg.sv -----
// bzpath_pkg: shared types and codes for the Bezier path point evaluator.
// Holds the coordinate pair and result types, item kinds and register indexes.
// No dependencies.
package bzpath_pkg;

	typedef struct packed {
		logic signed [31:0] y;
		logic signed [31:0] x;
	} vec_t;

	typedef struct packed {
		vec_t pt;
		vec_t pre;
		vec_t post;
		logic err;
	} res_t;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [0:0] CFG_NODE_COUNT = 1'd0;
	localparam logic [0:0] CFG_CYCLIC     = 1'd1;

endpackage

// ----- src/bezier_path_point_eval.sv -----
// bezier_path_point_eval: node store and de Casteljau evaluation of a cubic Bezier path.
// Uses bzpath_pkg for vector/result types, item kinds and register indexes.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer. kind = write stores
//   point, pre and post control of slot node_index; kind = query evaluates the path at
//   path_time (Q format with FRAC_BITS fraction bits) and yields one result on the
//   output channel (out_valid/out_ready). Writes yield nothing.
//   Config port: cfg_we with cfg_index 0 sets node_count, 1 sets cyclic; write only
//   while idle.
//   Throughput: one item per cycle while the skid register is empty. From input transfer
//   to out_valid an item passes one decode stage, one stage per remainder bit of the
//   segment index modulo node count, one memory read stage, three interpolation stages
//   and the output register.
//   All items pass the memory stage in order, so a query sees every earlier write.
//   Reset clears config, pipeline valids and the output; node memories are not
//   cleared and must be written before they are read.
//   When the receiver stalls, a skid register takes one more result and in_ready drops
//   the next cycle; the whole pipeline holds until the skid empties into the output.
module bezier_path_point_eval #(
	parameter int MAX_NODES = 256,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [8:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [7:0]         node_index,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] pre_x,
	input  logic signed [31:0] pre_y,
	input  logic signed [31:0] post_x,
	input  logic signed [31:0] post_y,
	input  logic signed [31:0] path_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] out_point_x,
	output logic signed [31:0] out_point_y,
	output logic signed [31:0] out_pre_x,
	output logic signed [31:0] out_pre_y,
	output logic signed [31:0] out_post_x,
	output logic signed [31:0] out_post_y,
	output logic               empty_error
);

	localparam int F  = FRAC_BITS;
	localparam int UW = 31 - F;
	localparam int IW = $clog2(MAX_NODES);
	localparam int PW = F + 36;
	localparam logic signed [F+1:0]  ONE_W = {2'b01, {F{1'b0}}};
	localparam logic signed [PW-1:0] HALF  = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

	typedef struct packed {
		logic               valid;
		logic               kind;
		logic [7:0]         idx;
		bzpath_pkg::vec_t   pt;
		bzpath_pkg::vec_t   pre;
		bzpath_pkg::vec_t   post;
		logic [F-1:0]       t;
		logic               neg;
		logic [UW-1:0]      u;
		logic [8:0]         rem;
	} front_t;

	typedef struct packed {
		logic         valid;
		logic         empty;
		logic         clamp;
		logic [F-1:0] t;
	} mctl_t;

	typedef struct packed {
		logic              valid;
		logic              alt;
		bzpath_pkg::res_t  alt_res;
		logic [F-1:0]      t;
		bzpath_pkg::vec_t  a;
		bzpath_pkg::vec_t  d;
		bzpath_pkg::vec_t  pre_i;
		bzpath_pkg::vec_t  post_j;
		bzpath_pkg::vec_t  p0;
		bzpath_pkg::vec_t  p1;
		bzpath_pkg::vec_t  p2;
	} lerp_t;

	typedef struct packed {
		logic             valid;
		bzpath_pkg::res_t res;
	} fin_t;

	function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic [F-1:0] t);
		logic signed [F+1:0]  wa;
		logic signed [F+1:0]  wb;
		logic signed [PW-1:0] s;
		wb = $signed({2'b00, t});
		wa = ONE_W - wb;
		s = a * wa + b * wb + HALF;
		return s[F+31:F];
	endfunction

	function automatic bzpath_pkg::vec_t lerpv(input bzpath_pkg::vec_t a,
		input bzpath_pkg::vec_t b, input logic [F-1:0] t);
		bzpath_pkg::vec_t r;
		r.x = lerp(a.x, b.x, t);
		r.y = lerp(a.y, b.y, t);
		return r;
	endfunction

	logic       [8:0] node_count_q;
	logic             cyclic_q;
	logic       [8:0] n_nodes;
	logic       [8:0] nm1;
	logic             en;

	logic             skid_valid_q;
	bzpath_pkg::res_t skid_q;
	logic             out_valid_q;
	bzpath_pkg::res_t out_q;

	front_t fr_s [0:UW];
	mctl_t  mem_s2;
	lerp_t  l1_s3;
	lerp_t  l2_s4;
	fin_t   l3_s5;

	bzpath_pkg::vec_t pa_pt_s2, pa_pre_s2, pa_post_s2;
	bzpath_pkg::vec_t pb_pt_s2, pb_pre_s2, pb_post_s2;
	bzpath_pkg::vec_t pt_mem   [MAX_NODES];
	bzpath_pkg::vec_t pre_mem  [MAX_NODES];
	bzpath_pkg::vec_t post_mem [MAX_NODES];

	assign en       = !skid_valid_q;
	assign in_ready = en;
	assign nm1      = n_nodes - 9'd1;
	assign n_nodes  = (32'(node_count_q) > 32'(MAX_NODES)) ? 9'(MAX_NODES) : node_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
			cyclic_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bzpath_pkg::CFG_NODE_COUNT: node_count_q <= cfg_wdata;
				bzpath_pkg::CFG_CYCLIC:     cyclic_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// decode
	front_t dec_d;
	always_comb begin
		dec_d        = '0;
		dec_d.valid  = in_valid;
		dec_d.kind   = kind;
		dec_d.idx    = node_index;
		dec_d.pt     = {point_y, point_x};
		dec_d.pre    = {pre_y, pre_x};
		dec_d.post   = {post_y, post_x};
		dec_d.t      = path_time[F-1:0];
		dec_d.neg    = path_time[31];
		dec_d.u      = path_time[31] ? ~path_time[F+UW-1:F] : path_time[F+UW-1:F];
		dec_d.rem    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_s[0] <= '0;
		end else if (en) begin
			fr_s[0] <= dec_d;
		end
	end

	// segment index modulo node count, one remainder bit per stage
	for (genvar k = 0; k < UW; k++) begin : g_div
		logic   [9:0] r2;
		front_t nx;
		always_comb begin
			nx = fr_s[k];
			r2 = {fr_s[k].rem, fr_s[k].u[UW-1-k]};
			nx.rem = (r2 >= {1'b0, n_nodes}) ? 9'(r2 - {1'b0, n_nodes}) : r2[8:0];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fr_s[k+1] <= '0;
			end else if (en) begin
				fr_s[k+1] <= nx;
			end
		end
	end

	// address select
	front_t  fl;
	logic    [8:0] ia, ib;
	logic    clamp, empty, wen;
	logic    [IW-1:0] addr_a, addr_b, addr_w;
	always_comb begin
		fl    = fr_s[UW];
		empty = (n_nodes == 9'd0);
		clamp = 1'b0;
		ia    = '0;
		ib    = '0;
		if (cyclic_q) begin
			ia = fl.neg ? nm1 - fl.rem : fl.rem;
			ib = (ia == nm1) ? 9'd0 : ia + 9'd1;
		end else if (fl.neg) begin
			clamp = 1'b1;
		end else if (32'(fl.u) >= 32'(nm1)) begin
			clamp = 1'b1;
			ia    = nm1;
			ib    = nm1;
		end else begin
			ia = 9'(fl.u);
			ib = ia + 9'd1;
		end
		addr_a = IW'(ia);
		addr_b = IW'(ib);
		addr_w = IW'(fl.idx);
		wen    = en && fl.valid && (fl.kind == bzpath_pkg::KIND_WRITE) &&
			(32'(fl.idx) < 32'(MAX_NODES));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (wen) begin
				pt_mem[addr_w]   <= fl.pt;
				pre_mem[addr_w]  <= fl.pre;
				post_mem[addr_w] <= fl.post;
			end
			pa_pt_s2   <= pt_mem[addr_a];
			pa_pre_s2  <= pre_mem[addr_a];
			pa_post_s2 <= post_mem[addr_a];
			pb_pt_s2   <= pt_mem[addr_b];
			pb_pre_s2  <= pre_mem[addr_b];
			pb_post_s2 <= post_mem[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_s2 <= '0;
		end else if (en) begin
			mem_s2.valid <= fl.valid && (fl.kind == bzpath_pkg::KIND_QUERY);
			mem_s2.empty <= empty;
			mem_s2.clamp <= clamp;
			mem_s2.t     <= fl.t;
		end
	end

	// interpolation levels
	lerp_t l1_d, l2_d;
	fin_t  l3_d;
	bzpath_pkg::vec_t abcd, pre_o, post_o;
	always_comb begin
		l1_d         = '0;
		l1_d.valid   = mem_s2.valid;
		l1_d.alt     = mem_s2.empty || mem_s2.clamp;
		l1_d.alt_res = '0;
		if (mem_s2.empty) begin
			l1_d.alt_res.err = 1'b1;
		end else begin
			l1_d.alt_res.pt   = pa_pt_s2;
			l1_d.alt_res.pre  = pa_pre_s2;
			l1_d.alt_res.post = pa_post_s2;
		end
		l1_d.t      = mem_s2.t;
		l1_d.a      = pa_pt_s2;
		l1_d.d      = pb_pt_s2;
		l1_d.pre_i  = pa_pre_s2;
		l1_d.post_j = pb_post_s2;
		l1_d.p0     = lerpv(pa_pt_s2, pa_post_s2, mem_s2.t);
		l1_d.p1     = lerpv(pa_post_s2, pb_pre_s2, mem_s2.t);
		l1_d.p2     = lerpv(pb_pre_s2, pb_pt_s2, mem_s2.t);

		l2_d    = l1_s3;
		l2_d.p0 = lerpv(l1_s3.p0, l1_s3.p1, l1_s3.t);
		l2_d.p1 = lerpv(l1_s3.p1, l1_s3.p2, l1_s3.t);

		abcd   = lerpv(l2_s4.p0, l2_s4.p1, l2_s4.t);
		pre_o  = (l2_s4.p0 == l2_s4.a) ? l2_s4.pre_i : l2_s4.p0;
		post_o = (l2_s4.p1 == l2_s4.d) ? l2_s4.post_j : l2_s4.p1;
		l3_d.valid = l2_s4.valid;
		if (l2_s4.alt) begin
			l3_d.res = l2_s4.alt_res;
		end else begin
			l3_d.res.pt   = abcd;
			l3_d.res.pre  = pre_o;
			l3_d.res.post = post_o;
			l3_d.res.err  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_s3 <= '0;
			l2_s4 <= '0;
			l3_s5 <= '0;
		end else if (en) begin
			l1_s3 <= l1_d;
			l2_s4 <= l2_d;
			l3_s5 <= l3_d;
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else if (en && l3_s5.valid) begin
			if (!out_valid_q || out_ready) begin
				out_q       <= l3_s5.res;
				out_valid_q <= 1'b1;
			end else begin
				skid_q       <= l3_s5.res;
				skid_valid_q <= 1'b1;
			end
		end else if (out_valid_q && out_ready) begin
			if (skid_valid_q) begin
				out_q        <= skid_q;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_point_x = out_q.pt.x;
	assign out_point_y = out_q.pt.y;
	assign out_pre_x   = out_q.pre.x;
	assign out_pre_y   = out_q.pre.y;
	assign out_post_x  = out_q.post.x;
	assign out_post_y  = out_q.post.y;
	assign empty_error = out_q.err;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output register is empty");

	a_frozen_on_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(l3_s5))
		else $error("pipeline moved while skid register was full");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.err) |-> (out_q.pt == '0 && out_q.pre == '0 && out_q.post == '0))
		else $error("empty path result carries nonzero fields");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(en && fl.valid && fl.kind == bzpath_pkg::KIND_WRITE) |=> !mem_s2.valid)
		else $error("write item turned into a result");

endmodule

// ----- test/tb_bezier_path_point_eval.sv -----
// Testbench for bezier_path_point_eval: random node writes and path queries.
// A scoreboard class predicts each query and checks every output transfer.
// Depends on bzpath_pkg and the bezier_path_point_eval RTL.
module tb_bezier_path_point_eval;
	timeunit 1ns;
	timeprecision 1ps;

	class path_scoreboard;
		bzpath_pkg::vec_t pts[256];
		bzpath_pkg::vec_t pres[256];
		bzpath_pkg::vec_t posts[256];
		int unsigned count;
		bit closed;
		bzpath_pkg::res_t pending[$];
		int errors;

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %h want %h", what, got, want);
			errors++;
		endtask

		function logic signed [31:0] mix(logic signed [31:0] a, logic signed [31:0] b,
				longint t);
			longint s;
			s = longint'(a) * (65536 - t) + longint'(b) * t + 32768;
			return 32'(s >>> 16);
		endfunction

		function bzpath_pkg::vec_t mix2(bzpath_pkg::vec_t a, bzpath_pkg::vec_t b,
				longint t);
			bzpath_pkg::vec_t r;
			r.x = mix(a.x, b.x, t);
			r.y = mix(a.y, b.y, t);
			return r;
		endfunction

		function bzpath_pkg::res_t eval_path(logic signed [31:0] ptime);
			bzpath_pkg::res_t r;
			longint n, p, seg, t, i, j, e;
			bzpath_pkg::vec_t ab, bc, cd, abc, bcd;
			r = '0;
			n = (count > 256) ? 256 : count;
			if (n == 0) begin
				r.err = 1'b1;
				return r;
			end
			p = longint'(ptime);
			seg = p >>> 16;
			t = p & 65535;
			if (closed) begin
				i = seg % n;
				if (i < 0) i += n;
				j = (i + 1) % n;
			end else if (seg < 0 || seg >= n - 1) begin
				e = (seg < 0) ? 0 : n - 1;
				r.pt = pts[e];
				r.pre = pres[e];
				r.post = posts[e];
				return r;
			end else begin
				i = seg;
				j = seg + 1;
			end
			ab = mix2(pts[i], posts[i], t);
			bc = mix2(posts[i], pres[j], t);
			cd = mix2(pres[j], pts[j], t);
			abc = mix2(ab, bc, t);
			bcd = mix2(bc, cd, t);
			r.pt = mix2(abc, bcd, t);
			r.pre = (abc == pts[i]) ? pres[i] : abc;
			r.post = (bcd == pts[j]) ? posts[j] : bcd;
			return r;
		endfunction

		function void note(logic k, logic [7:0] idx, bzpath_pkg::vec_t pt,
				bzpath_pkg::vec_t pr, bzpath_pkg::vec_t po, logic signed [31:0] ptime);
			if (k == bzpath_pkg::KIND_WRITE) begin
				pts[idx] = pt;
				pres[idx] = pr;
				posts[idx] = po;
			end else begin
				pending.push_back(eval_path(ptime));
			end
		endfunction

		task check(bzpath_pkg::res_t got);
			bzpath_pkg::res_t w;
			if (pending.size() == 0) begin
				report("unexpected output transfer", '0, '0);
				return;
			end
			w = pending.pop_front();
			if (got.pt.x !== w.pt.x) report("point_x", got.pt.x, w.pt.x);
			if (got.pt.y !== w.pt.y) report("point_y", got.pt.y, w.pt.y);
			if (got.pre.x !== w.pre.x) report("pre_x", got.pre.x, w.pre.x);
			if (got.pre.y !== w.pre.y) report("pre_y", got.pre.y, w.pre.y);
			if (got.post.x !== w.post.x) report("post_x", got.post.x, w.post.x);
			if (got.post.y !== w.post.y) report("post_y", got.post.y, w.post.y);
			if (got.err !== w.err) report("empty_error", got.err, w.err);
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [8:0] cfg_wdata;
	logic in_valid, in_ready, kind, out_valid, out_ready, empty_error;
	logic [7:0] node_index;
	logic signed [31:0] point_x, point_y, pre_x, pre_y, post_x, post_y, path_time;
	logic signed [31:0] out_point_x, out_point_y, out_pre_x, out_pre_y;
	logic signed [31:0] out_post_x, out_post_y;

	path_scoreboard sb = new();
	bit calm;
	int unsigned cycles;

	bezier_path_point_eval dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		cfg_we <= 0; cfg_index <= '0; cfg_wdata <= '0;
		in_valid <= 0; kind <= 0; node_index <= '0;
		point_x <= 0; point_y <= 0; pre_x <= 0; pre_y <= 0;
		post_x <= 0; post_y <= 0; path_time <= 0;
		out_ready <= 0;
	end

	always @(posedge clk) begin
		out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
		if (out_valid && out_ready)
			sb.check('{pt: '{y: out_point_y, x: out_point_x},
				pre: '{y: out_pre_y, x: out_pre_x},
				post: '{y: out_post_y, x: out_post_x}, err: empty_error});
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 2000000) begin
			$display("tb_bezier_path_point_eval: errors");
			$finish;
		end
	end

	task put(logic k, logic [7:0] idx, bzpath_pkg::vec_t pt, bzpath_pkg::vec_t pr,
			bzpath_pkg::vec_t po, logic signed [31:0] ptime);
		while (!calm && $urandom_range(99) < 25) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; kind <= k; node_index <= idx;
		point_x <= pt.x; point_y <= pt.y; pre_x <= pr.x; pre_y <= pr.y;
		post_x <= po.x; post_y <= po.y; path_time <= ptime;
		do @(posedge clk); while (!in_ready);
		sb.note(k, idx, pt, pr, po, ptime);
	endtask

	task drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task set_reg(logic [0:0] idx, logic [8:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == bzpath_pkg::CFG_NODE_COUNT) sb.count = val;
		else sb.closed = val[0];
	endtask

	function bzpath_pkg::vec_t rand_vec(bit coarse);
		bzpath_pkg::vec_t v;
		if (coarse) begin
			v.x = $signed($urandom_range(0, 6) - 3) <<< 16;
			v.y = $signed($urandom_range(0, 6) - 3) <<< 16;
		end else begin
			v.x = $urandom;
			v.y = $urandom;
		end
		return v;
	endfunction

	function logic signed [31:0] rand_time();
		int s;
		case ($urandom_range(3))
			0: return $urandom;
			1: return {$urandom_range(0, 5) == 0 ? 16'h0 : 16'(sb.count - 1), 16'h0};
			default: begin
				s = int'($urandom_range(0, sb.count + 4)) - 2;
				return {16'(s), 16'($urandom)};
			end
		endcase
	endfunction

	initial begin
		int cnts[10];
		bit cyc[10];
		bzpath_pkg::vec_t hi, lo, p;
		bit coarse;
		cnts = '{0, 1, 2, 2, 5, 256, 256, 300, 3, 511};
		cyc = '{0, 0, 0, 1, 1, 0, 1, 1, 0, 0};
		hi = '{y: 32'sh7fffffff, x: 32'sh7fffffff};
		lo = '{y: 32'sh80000000, x: 32'sh80000000};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		put(bzpath_pkg::KIND_WRITE, 0, hi, lo, hi, 0);
		put(bzpath_pkg::KIND_WRITE, 1, lo, hi, lo, 0);
		for (int k = 2; k < 256; k++)
			put(bzpath_pkg::KIND_WRITE, k, rand_vec(k[0]), rand_vec(k[0]), rand_vec(0),
				$urandom);
		put(bzpath_pkg::KIND_QUERY, 8'hff, hi, hi, hi, 0);
		drain();
		for (int ph = 0; ph < 10; ph++) begin
			set_reg(bzpath_pkg::CFG_NODE_COUNT, cnts[ph]);
			set_reg(bzpath_pkg::CFG_CYCLIC, cyc[ph]);
			calm = (ph == 6);
			put(bzpath_pkg::KIND_QUERY, 0, hi, hi, hi, 32'sh00000000);
			put(bzpath_pkg::KIND_QUERY, 0, hi, hi, hi, 32'sh7fffffff);
			put(bzpath_pkg::KIND_QUERY, 0, hi, hi, hi, 32'sh80000000);
			put(bzpath_pkg::KIND_QUERY, 0, hi, hi, hi, -32'sd1);
			put(bzpath_pkg::KIND_QUERY, 0, hi, hi, hi, 32'sh0000ffff);
			put(bzpath_pkg::KIND_QUERY, 0, hi, hi, hi, 32'sh00010000);
			for (int k = 0; k < 55; k++) begin
				if (ph == 4 && k == 40) drain();
				if ($urandom_range(99) < 30) begin
					coarse = $urandom_range(1);
					p = rand_vec(coarse);
					put(bzpath_pkg::KIND_WRITE, ($urandom_range(3) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, 6)), p, rand_vec(coarse),
						$urandom_range(3) == 0 ? p : rand_vec(coarse), $urandom);
				end else begin
					put(bzpath_pkg::KIND_QUERY, $urandom, rand_vec(0), rand_vec(0),
						rand_vec(0), rand_time());
				end
			end
			drain();
		end
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb_bezier_path_point_eval: clean");
		end else begin
			$display("tb_bezier_path_point_eval: errors");
		end
		$finish;
	end
endmodule

// ----- files.f -----
src/bzpath_pkg.sv
src/bezier_path_point_eval.sv
test/tb_bezier_path_point_eval.sv
